// ===== hw/rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and codes for the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // item function codes
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_LOADED = 2'd0;
    localparam logic [1:0] STATUS_ALLOC  = 2'd1;
    localparam logic [1:0] STATUS_NOFIT  = 2'd2;

    // reset value of the block count register
    localparam logic [4:0] BLOCK_COUNT_RESET = 5'd16;

    // control from the sequencer to the fit unit
    typedef struct packed {
        logic start;   // new request: forget the previous best
        logic valid;   // a candidate beat is on the data lines
        logic free;    // candidate block is free
    } bfa_scan_ctl_t;

endpackage

// ===== hw/rtl/bfa_fit_unit.sv =====
// ----------------------------------------------------------------------------
// bfa_fit_unit
// Shared subtract-and-compare unit: takes one candidate block per cycle and
// keeps the best fit seen so far (smallest leftover, lowest index on a tie).
// ----------------------------------------------------------------------------
module bfa_fit_unit
    import bfa_pkg::*;
#(
    parameter int IDX_W      = 4,
    parameter int SIZE_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bfa_scan_ctl_t         ctl,
    input  logic [SIZE_WIDTH-1:0] req_size,
    input  logic [SIZE_WIDTH-1:0] cand_size,
    input  logic [IDX_W-1:0]      cand_idx,
    output logic                  best_found,
    output logic [IDX_W-1:0]      best_idx,
    output logic [SIZE_WIDTH-1:0] best_left
);

    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [SIZE_WIDTH-1:0] left_reg, left_next;
    logic                  fits;
    logic [SIZE_WIDTH-1:0] left;
    logic                  take;

    // one subtract and two compares per candidate
    always_comb begin
        fits = ctl.free && (cand_size >= req_size);
        left = cand_size - req_size;
        // strict less-than keeps the lower index on a tie
        take = ctl.valid && fits && (!found_reg || (left < left_reg));

        found_next = found_reg;
        idx_next   = idx_reg;
        left_next  = left_reg;
        if (ctl.start) begin
            found_next = 1'b0;
        end else if (take) begin
            found_next = 1'b1;
            idx_next   = cand_idx;
            left_next  = left;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
        idx_reg  <= idx_next;
        left_reg <= left_next;
    end

    assign best_found = found_reg;
    assign best_idx   = idx_reg;
    assign best_left  = left_reg;

endmodule

// ===== hw/rtl/best_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over a table of memory blocks: loads set a block's size
// and free it, requests scan the free blocks and claim the tightest fit.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_        in         func, block_index, amount
//  m_        out        status, chosen_block, fragment
//  cfg_      in         block_count
//
//  A load goes from acceptance to the response state. A request scans
//  limit = min(block_count, NUM_BLOCKS) blocks: one size table read and one
//  fit-unit compare per block, then drain, decision and response states.
//  s_ready is high only while idle. A finished result waits in the output
//  register; the next item may be accepted meanwhile.
//  Reset clears all free bits at once; the size table needs no clearing.
// ----------------------------------------------------------------------------
module best_fit_block_allocator
    import bfa_pkg::*;
#(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // item input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [3:0]  s_block_index,
    input  logic [15:0] s_amount,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_chosen_block,
    output logic [15:0] m_fragment,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_block_count
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_RESP
    } state_t;

    state_t                state_reg;
    logic [4:0]            block_count_reg;
    logic [NUM_BLOCKS-1:0] free_reg;
    logic [IDX_W-1:0]      addr_reg;
    logic [SIZE_WIDTH-1:0] req_reg;
    logic                  cand_vld_reg;
    logic                  cand_free_reg;
    logic [IDX_W-1:0]      cand_idx_reg;
    logic [SIZE_WIDTH-1:0] rd_data_reg;
    logic [1:0]            pend_status_reg;
    logic [3:0]            pend_block_reg;
    logic [15:0]           pend_frag_reg;
    logic                  m_valid_reg;
    logic [1:0]            m_status_reg;
    logic [3:0]            m_block_reg;
    logic [15:0]           m_frag_reg;

    logic [SIZE_WIDTH-1:0] size_mem [NUM_BLOCKS];

    logic                  s_beat;
    logic                  load_beat;
    logic                  load_hit;
    logic [IDX_W-1:0]      load_addr;
    logic [SIZE_WIDTH-1:0] amount_w;
    logic [CNT_W-1:0]      limit;
    logic                  scan_last;
    logic                  out_free;
    bfa_scan_ctl_t         fit_ctl;
    logic                  fit_found;
    logic [IDX_W-1:0]      fit_idx;
    logic [SIZE_WIDTH-1:0] fit_left;

    // handshake and decode
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_beat    = s_valid && s_ready;
    assign load_beat = s_beat && (s_func == FUNC_LOAD);
    assign load_hit  = 32'(s_block_index) < 32'(NUM_BLOCKS);
    assign load_addr = IDX_W'(s_block_index);
    assign amount_w  = SIZE_WIDTH'(s_amount);
    assign out_free  = !m_valid_reg || m_ready;

    // search limit: counts above the table size are clamped
    assign limit = (32'(block_count_reg) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                            : CNT_W'(block_count_reg);
    assign scan_last = (CNT_W'(addr_reg) + CNT_W'(1)) == limit;

    // size table: one write port for loads, one registered read port for the scan
    always_ff @(posedge aclk) begin
        if (load_beat && load_hit) begin
            size_mem[load_addr] <= amount_w;
        end
        rd_data_reg <= size_mem[addr_reg];
    end

    // shared fit unit
    assign fit_ctl.start = s_beat && (s_func == FUNC_REQUEST);
    assign fit_ctl.valid = cand_vld_reg;
    assign fit_ctl.free  = cand_free_reg;

    bfa_fit_unit #(
        .IDX_W      (IDX_W),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_fit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (fit_ctl),
        .req_size   (req_reg),
        .cand_size  (rd_data_reg),
        .cand_idx   (cand_idx_reg),
        .best_found (fit_found),
        .best_idx   (fit_idx),
        .best_left  (fit_left)
    );

    // sequencer, free bits and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            block_count_reg <= BLOCK_COUNT_RESET;
            free_reg        <= '0;
            addr_reg        <= '0;
            cand_vld_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                block_count_reg <= cfg_block_count;
            end

            // candidate beat pipeline alongside the table read
            cand_vld_reg  <= (state_reg == S_SCAN);
            cand_free_reg <= free_reg[addr_reg];
            cand_idx_reg  <= addr_reg;

            // a taken beat is dropped unless the next one replaces it below
            if (m_valid_reg && m_ready && (state_reg != S_RESP)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    addr_reg <= '0;
                    if (s_beat) begin
                        req_reg <= amount_w;
                        if (s_func == FUNC_LOAD) begin
                            if (load_hit) begin
                                free_reg[load_addr] <= 1'b1;
                            end
                            pend_status_reg <= STATUS_LOADED;
                            pend_block_reg  <= '0;
                            pend_frag_reg   <= '0;
                            state_reg       <= S_RESP;
                        end else if (limit == '0) begin
                            state_reg <= S_DECIDE;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_last) begin
                        state_reg <= S_DRAIN;
                    end else begin
                        addr_reg <= addr_reg + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (fit_found) begin
                        free_reg[fit_idx] <= 1'b0;
                        pend_status_reg   <= STATUS_ALLOC;
                        pend_block_reg    <= 4'(fit_idx);
                        pend_frag_reg     <= 16'(fit_left);
                    end else begin
                        pend_status_reg <= STATUS_NOFIT;
                        pend_block_reg  <= '0;
                        pend_frag_reg   <= '0;
                    end
                    state_reg <= S_RESP;
                end
                S_RESP: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= pend_status_reg;
                        m_block_reg  <= pend_block_reg;
                        m_frag_reg   <= pend_frag_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_chosen_block = m_block_reg;
    assign m_fragment     = m_frag_reg;

    // the block claimed must still be free when the decision is taken
    a_claim_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECIDE && fit_found) |-> free_reg[fit_idx])
        else $error("claimed block is not free");

    // scan address stays below the search limit
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (CNT_W'(addr_reg) < limit))
        else $error("scan address beyond limit");

    // a no-fit result carries zero index and fragment
    a_nofit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_NOFIT) |-> (m_chosen_block == '0 && m_fragment == '0))
        else $error("no-fit result with non-zero fields");

    // an allocation names a block inside the table
    a_alloc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_ALLOC) |-> (32'(m_chosen_block) < 32'(NUM_BLOCKS)))
        else $error("allocated block outside the table");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the best-fit block allocator.
// Load and request beats go in with random gaps (back to back in one phase)
// while the result side stalls at random. Every result is predicted from a
// shadow copy of the block sizes and free bits and checked in order. The block
// count register is swept between phases, with its extremes.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bfa_pkg::*;

    localparam int TABLE_DEPTH      = 16;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int HOLD_CYCLES      = 400;
    localparam int CYCLE_LIMIT      = 1000000;

    typedef struct packed {
        logic        func;
        logic [3:0]  index;
        logic [15:0] amount;
    } alloc_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  chosen;
        logic [15:0] fragment;
    } alloc_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [3:0]  s_block_index;
    logic [15:0] s_amount;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [3:0]  m_chosen_block;
    logic [15:0] m_fragment;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_block_count;

    // shadow of the block state
    logic [15:0] shadow_size [TABLE_DEPTH];
    bit          shadow_free [TABLE_DEPTH];
    logic [4:0]  shadow_count;

    alloc_item_t   item_backlog [$];
    alloc_result_t pending_results [$];
    alloc_item_t   next_item;
    alloc_result_t want;

    int  items_queued;
    int  items_accepted;
    int  errors;
    int  cycle_count;
    int  send_gap;
    int  sink_wait;
    int  hold_left;
    int  hold_request;
    bit  idle_on;
    bit  s_taken;
    bit  next_valid;
    logic [15:0] palette [6];

    best_fit_block_allocator #(
        .NUM_BLOCKS (TABLE_DEPTH),
        .SIZE_WIDTH (16)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_block_index   (s_block_index),
        .s_amount        (s_amount),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_chosen_block  (m_chosen_block),
        .m_fragment      (m_fragment),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_block_count (cfg_block_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // apply one accepted beat to the shadow state and work out its result
    function automatic alloc_result_t load_or_allocate(input logic func,
                                                       input logic [3:0] idx,
                                                       input logic [15:0] amt);
        alloc_result_t r;
        int            limit;
        int            best_j;
        bit            found;
        logic [15:0]   best_left;
        r         = '0;
        found     = 1'b0;
        best_j    = 0;
        best_left = '0;
        if (func == FUNC_LOAD) begin
            shadow_size[idx] = amt;
            shadow_free[idx] = 1'b1;
            r.status = STATUS_LOADED;
            return r;
        end
        // counts above the table size search the whole table
        limit = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
        for (int j = 0; j < limit; j++) begin
            if (shadow_free[j] && shadow_size[j] >= amt) begin
                if (!found || (shadow_size[j] - amt) < best_left) begin
                    found     = 1'b1;
                    best_left = shadow_size[j] - amt;
                    best_j    = j;
                end
            end
        end
        if (!found) begin
            r.status = STATUS_NOFIT;
            return r;
        end
        shadow_free[best_j] = 1'b0;
        r.status   = STATUS_ALLOC;
        r.chosen   = best_j[3:0];
        r.fragment = best_left;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 60);
    endfunction

    // sizes clustered on a few values so that ties and exact fits are common
    function automatic logic [15:0] pick_amount();
        int          r;
        logic [15:0] p;
        logic [15:0] a;
        r = $urandom_range(0, 99);
        p = palette[$urandom_range(0, 5)];
        if (r < 30)      a = p;
        else if (r < 50) a = p - 16'($urandom_range(0, 3));
        else if (r < 65) a = p + 16'($urandom_range(1, 3));
        else if (r < 80) a = 16'($urandom_range(0, 31));
        else if (r < 92) a = 16'($urandom);
        else if (r < 96) a = 16'hFFFF;
        else             a = 16'h0000;
        return a;
    endfunction

    task automatic queue_item(input logic func, input logic [3:0] idx,
                              input logic [15:0] amt);
        alloc_item_t it;
        it.func   = func;
        it.index  = idx;
        it.amount = amt;
        item_backlog = {item_backlog, it};
        items_queued++;
    endtask

    // wait for every beat to be taken and answered, then let the block settle
    task automatic wait_idle();
        @(negedge aclk);
        while (items_accepted != items_queued || pending_results.size() != 0)
            @(negedge aclk);
        repeat (24) @(negedge aclk);
    endtask

    task automatic write_block_count(input logic [4:0] value);
        @(negedge aclk);
        cfg_valid       <= 1'b1;
        cfg_block_count <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        shadow_count = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input int n, input int span);
        int          r;
        logic [3:0]  idx;
        for (int i = 0; i < 6; i++)
            palette[i] = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 64))
                                                     : 16'($urandom);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            // loads mostly land inside the searched range
            if (r < 10) idx = 4'($urandom_range(0, 15));
            else        idx = 4'($urandom_range(0, span - 1));
            if ($urandom_range(0, 99) < 45) queue_item(FUNC_LOAD, idx, pick_amount());
            else                            queue_item(FUNC_REQUEST, 4'($urandom),
                                                       pick_amount());
        end
    endtask

    // stimulus and phase control
    initial begin
        int          phase_counts [7];
        logic [15:0] start_sizes [16];
        int          span;
        phase_counts = '{1, 31, 0, 5, 17, 8, 16};
        start_sizes  = '{16'd100, 16'd65535, 16'd0, 16'd100, 16'd37, 16'd500,
                         16'd1, 16'd65534, 16'd250, 16'd251, 16'd1000, 16'd2,
                         16'd99, 16'd4096, 16'd32768, 16'd7};
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_func          = FUNC_LOAD;
        s_block_index   = '0;
        s_amount        = '0;
        m_ready         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_block_count = '0;
        idle_on         = 1'b1;
        shadow_count    = BLOCK_COUNT_RESET;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            shadow_size[i] = '0;
            shadow_free[i] = 1'b0;
        end
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_block_count(BLOCK_COUNT_RESET);

        // fill every slot first so that no search touches an unwritten size
        for (int i = 0; i < 16; i++)
            queue_item(FUNC_LOAD, i[3:0], start_sizes[i]);
        queue_item(FUNC_REQUEST, 4'hF, 16'd0);      // zero size takes the empty block
        queue_item(FUNC_REQUEST, 4'h0, 16'd100);    // tie, lower index wins
        queue_item(FUNC_REQUEST, 4'hA, 16'd100);    // then the other one
        queue_item(FUNC_REQUEST, 4'h5, 16'd65535);  // largest request, exact fit
        queue_item(FUNC_REQUEST, 4'h3, 16'd65535);  // nothing left that fits
        queue_item(FUNC_REQUEST, 4'hC, 16'd3);      // smallest leftover among many
        queue_item(FUNC_LOAD, 4'h0, 16'd100);       // reload of a used block
        queue_item(FUNC_REQUEST, 4'h9, 16'd98);
        wait_idle();

        foreach (phase_counts[p]) begin
            write_block_count(phase_counts[p][4:0]);
            idle_on = (phase_counts[p] != 17);
            span = (phase_counts[p] < 1) ? 1 :
                   (phase_counts[p] > TABLE_DEPTH) ? TABLE_DEPTH : phase_counts[p];
            run_random_phase(RANDOM_PER_PHASE, span);
            // long hold-off on the result side to back the block up
            if (phase_counts[p] == 31) begin
                @(posedge aclk);
                hold_request = HOLD_CYCLES;
            end
            wait_idle();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // item driver
    always @(negedge aclk) begin
        next_valid = s_valid;
        if (s_taken) begin
            next_valid = 1'b0;
            s_taken    = 1'b0;
        end
        if (aresetn && !next_valid) begin
            if (send_gap != 0) begin
                send_gap--;
            end else if (item_backlog.size() != 0) begin
                next_item = item_backlog.pop_front();
                s_func        <= next_item.func;
                s_block_index <= next_item.index;
                s_amount      <= next_item.amount;
                next_valid    = 1'b1;
                send_gap      = idle_on ? pick_gap() : 0;
            end
        end
        s_valid <= next_valid;
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (sink_wait != 0) begin
            sink_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
                sink_wait = pick_gap();
        end
    end

    // monitor: check result beats first, then predict for the accepted item
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat: status %0d block %0d fragment %0d",
                             $time, m_status, m_chosen_block, m_fragment);
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                    end
                    if (m_chosen_block !== want.chosen) begin
                        errors++;
                        $display("%0t: chosen_block expected %0d actual %0d",
                                 $time, want.chosen, m_chosen_block);
                    end
                    if (m_fragment !== want.fragment) begin
                        errors++;
                        $display("%0t: fragment expected %0d actual %0d",
                                 $time, want.fragment, m_fragment);
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_results = {pending_results,
                                   load_or_allocate(s_func, s_block_index, s_amount)};
                items_accepted++;
                s_taken = 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
